FILE: hw/rtl/abg_pkg.sv
// Shared types, widths and codes for the anchor box generator.
package abg_pkg;

  // Prior table size and derived widths
  localparam int MAX_PRIORS  = 16;
  localparam int PRIOR_IDX_W = $clog2(MAX_PRIORS);
  localparam int CNT_W       = $clog2(MAX_PRIORS + 1);

  // Field widths fixed by the interface
  localparam int HALF_W     = 16;
  localparam int CELL_W     = 10;
  localparam int STEP_W     = 16;
  localparam int OFFSET_W   = 8;
  localparam int INV_W      = 25;
  localparam int PCOUNT_W   = 5;
  localparam int VAR_W      = 16;
  localparam int VARS_W     = 4 * VAR_W;
  localparam int COORD_W    = 16;
  localparam int CFG_DATA_W = 64;

  // Internal fixed-point widths
  localparam int CPOS_W   = CELL_W + OFFSET_W;      // cell position, Q.8
  localparam int CENTER_W = CPOS_W + STEP_W;        // pixel center, Q.12
  localparam int HALF12_W = HALF_W + 8;             // half size, Q.12
  localparam int EDGE_W   = CENTER_W + 2;           // signed edge, Q.12
  localparam int SPLIT_W  = 18;                     // low slice of edge
  localparam int HI_W     = EDGE_W - SPLIT_W;       // signed high slice
  localparam int LO_PROD_W = SPLIT_W + INV_W;
  localparam int HI_PROD_W = HI_W + INV_W + 1;
  localparam int PROD_W    = HI_PROD_W + SPLIT_W;   // full Q.36 product
  localparam int ROUND_SH  = 22;
  localparam int RES_W     = PROD_W - ROUND_SH;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_STEP_X      = 3'd0,
    CFG_STEP_Y      = 3'd1,
    CFG_CENTER_OFS  = 3'd2,
    CFG_INV_WIDTH   = 3'd3,
    CFG_INV_HEIGHT  = 3'd4,
    CFG_CLIP_EN     = 3'd5,
    CFG_PRIOR_COUNT = 3'd6,
    CFG_VARIANCES   = 3'd7
  } cfg_index_t;

  // Item classes
  typedef enum logic {
    ITEM_LOAD = 1'b0,
    ITEM_CELL = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step_x;
    logic [STEP_W-1:0]   step_y;
    logic [OFFSET_W-1:0] center_offset;
    logic [INV_W-1:0]    inv_image_width;
    logic [INV_W-1:0]    inv_image_height;
    logic                clip_enable;
    logic [PCOUNT_W-1:0] prior_count;
    logic [VARS_W-1:0]   variances_packed;
  } cfg_t;

  // One classified item between front and back
  typedef struct packed {
    item_kind_t             kind;
    logic [PRIOR_IDX_W-1:0] prior_index;
    logic [HALF_W-1:0]      half_width;
    logic [HALF_W-1:0]      half_height;
    logic [CENTER_W-1:0]    cx;
    logic [CENTER_W-1:0]    cy;
  } queue_entry_t;

endpackage

FILE: hw/rtl/abg_if.sv
// Valid/ready channel interfaces for input items and output boxes.
interface abg_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  prior_index;
  logic [15:0] load_half_width;
  logic [15:0] load_half_height;
  logic [9:0]  cell_x;
  logic [9:0]  cell_y;

  modport source (
    output valid, action, prior_index, load_half_width, load_half_height, cell_x, cell_y,
    input  ready
  );
  modport sink (
    input  valid, action, prior_index, load_half_width, load_half_height, cell_x, cell_y,
    output ready
  );
endinterface

interface abg_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         box_prior;
  logic signed [15:0] x_min;
  logic signed [15:0] y_min;
  logic signed [15:0] x_max;
  logic signed [15:0] y_max;
  logic [15:0]        var_x;
  logic [15:0]        var_y;
  logic [15:0]        var_w;
  logic [15:0]        var_h;
  logic               last_box;

  modport source (
    output valid, box_prior, x_min, y_min, x_max, y_max, var_x, var_y, var_w, var_h,
           last_box,
    input  ready
  );
  modport sink (
    input  valid, box_prior, x_min, y_min, x_max, y_max, var_x, var_y, var_w, var_h,
           last_box,
    output ready
  );
endinterface

FILE: hw/rtl/abg_front.sv
// Front end: accepts items, classifies them and forms the cell center in pixels.
module abg_front (
  input  abg_pkg::cfg_t         cfg,
  abg_in_if.sink                in_ch,
  input  logic                  q_ready,
  output logic                  push,
  output abg_pkg::queue_entry_t entry
);
  import abg_pkg::*;

  logic [CPOS_W-1:0] cx_pos;
  logic [CPOS_W-1:0] cy_pos;

  // Transfer into the queue whenever it has room
  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid && q_ready;

  // Cell position in Q.8, then times the stride for a Q.12 center
  always_comb begin
    cx_pos = {in_ch.cell_x, 8'h00} + CPOS_W'(cfg.center_offset);
    cy_pos = {in_ch.cell_y, 8'h00} + CPOS_W'(cfg.center_offset);

    entry.kind        = in_ch.action ? ITEM_CELL : ITEM_LOAD;
    entry.prior_index = PRIOR_IDX_W'(in_ch.prior_index);
    entry.half_width  = in_ch.load_half_width;
    entry.half_height = in_ch.load_half_height;
    entry.cx          = CENTER_W'(cx_pos) * CENTER_W'(cfg.step_x);
    entry.cy          = CENTER_W'(cy_pos) * CENTER_W'(cfg.step_y);
  end

endmodule

FILE: hw/rtl/abg_queue.sv
// Short FIFO of classified items between front and back.
module abg_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  abg_pkg::queue_entry_t wr_entry,
  output logic                  ready,
  output logic                  head_valid,
  output abg_pkg::queue_entry_t head,
  input  logic                  pop
);
  import abg_pkg::*;

  queue_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign ready      = (count != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

FILE: hw/rtl/abg_back.sv
// Back end: prior table, box sequencer, normalizing multiply and output register.
module abg_back (
  input  logic                  clk,
  input  logic                  rst,
  input  abg_pkg::cfg_t         cfg,
  input  logic                  head_valid,
  input  abg_pkg::queue_entry_t head,
  output logic                  pop,
  abg_out_if.source             out_ch
);
  import abg_pkg::*;

  // Limit a rounded Q.14 result to the Q2.14 range with clip or saturation
  function automatic logic [COORD_W-1:0] limit_coord(input logic signed [RES_W-1:0] r,
                                                     input logic clip);
    logic signed [RES_W-1:0] lo;
    logic signed [RES_W-1:0] hi;
    logic signed [RES_W-1:0] v;
    lo = clip ? RES_W'(0) : -(RES_W'(32768));
    hi = clip ? RES_W'(16384) : RES_W'(32767);
    v  = r;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[COORD_W-1:0];
  endfunction

  logic [HALF_W-1:0]        tbl_w [MAX_PRIORS];
  logic [HALF_W-1:0]        tbl_h [MAX_PRIORS];
  logic [PRIOR_IDX_W-1:0]   cnt;
  logic [CNT_W-1:0]         n_boxes;
  logic                     advance;
  logic                     is_cell;
  logic                     issue;
  logic                     last_issue;

  logic [HALF12_W-1:0]      hw12;
  logic [HALF12_W-1:0]      hh12;
  logic signed [EDGE_W-1:0] edge_v [4];
  logic [INV_W-1:0]         inv_v  [4];
  logic [LO_PROD_W-1:0]     lo_prod [4];
  logic signed [HI_PROD_W-1:0] hi_prod [4];

  logic                     s1_valid;
  logic [PRIOR_IDX_W-1:0]   s1_prior;
  logic                     s1_last;
  logic [LO_PROD_W-1:0]     s1_lo [4];
  logic signed [HI_PROD_W-1:0] s1_hi [4];

  logic signed [PROD_W-1:0] full_prod [4];
  logic signed [PROD_W-1:0] rounded   [4];
  logic [COORD_W-1:0]       coord     [4];

  logic                     o_valid;

  // Sequencer: one box per cycle unless stalled, pop the item with its last box
  assign n_boxes    = (cfg.prior_count > CNT_W'(MAX_PRIORS)) ? CNT_W'(MAX_PRIORS)
                                                             : CNT_W'(cfg.prior_count);
  assign advance    = !o_valid || out_ch.ready;
  assign is_cell    = head_valid && (head.kind == ITEM_CELL);
  assign last_issue = (CNT_W'(cnt) + 1'b1) == n_boxes;
  assign issue      = is_cell && (n_boxes != '0) && advance;
  assign pop        = head_valid && ((head.kind == ITEM_LOAD) || (n_boxes == '0) ||
                                     (advance && last_issue));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (pop) begin
      cnt <= '0;
    end else if (issue) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Prior table
  always_ff @(posedge clk) begin
    if (head_valid && (head.kind == ITEM_LOAD)) begin
      tbl_w[head.prior_index] <= head.half_width;
      tbl_h[head.prior_index] <= head.half_height;
    end
  end

  // Edges and split partial products: order x_min, y_min, x_max, y_max
  always_comb begin
    hw12 = {tbl_w[cnt], 8'h00};
    hh12 = {tbl_h[cnt], 8'h00};
    edge_v[0] = $signed({2'b00, head.cx}) - $signed(EDGE_W'(hw12));
    edge_v[1] = $signed({2'b00, head.cy}) - $signed(EDGE_W'(hh12));
    edge_v[2] = $signed({2'b00, head.cx}) + $signed(EDGE_W'(hw12));
    edge_v[3] = $signed({2'b00, head.cy}) + $signed(EDGE_W'(hh12));
    inv_v[0]  = cfg.inv_image_width;
    inv_v[1]  = cfg.inv_image_height;
    inv_v[2]  = cfg.inv_image_width;
    inv_v[3]  = cfg.inv_image_height;
    for (int k = 0; k < 4; k++) begin
      lo_prod[k] = LO_PROD_W'(edge_v[k][SPLIT_W-1:0]) * LO_PROD_W'(inv_v[k]);
      hi_prod[k] = HI_PROD_W'($signed(edge_v[k][EDGE_W-1:SPLIT_W])) *
                   $signed(HI_PROD_W'(inv_v[k]));
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prior <= cnt;
      s1_last  <= last_issue;
      for (int k = 0; k < 4; k++) begin
        s1_lo[k] <= lo_prod[k];
        s1_hi[k] <= hi_prod[k];
      end
    end
  end

  // Recombine, round half up, then clip or saturate
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      full_prod[k] = ($signed(PROD_W'(s1_hi[k])) <<< SPLIT_W) +
                     $signed(PROD_W'(s1_lo[k]));
      rounded[k]   = full_prod[k] + $signed(PROD_W'(1) << (ROUND_SH - 1));
      coord[k]     = limit_coord(rounded[k][PROD_W-1:ROUND_SH], cfg.clip_enable);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.box_prior <= 4'(s1_prior);
      out_ch.x_min     <= coord[0];
      out_ch.y_min     <= coord[1];
      out_ch.x_max     <= coord[2];
      out_ch.y_max     <= coord[3];
      out_ch.var_x     <= cfg.variances_packed[VAR_W-1:0];
      out_ch.var_y     <= cfg.variances_packed[2*VAR_W-1:VAR_W];
      out_ch.var_w     <= cfg.variances_packed[3*VAR_W-1:2*VAR_W];
      out_ch.var_h     <= cfg.variances_packed[4*VAR_W-1:3*VAR_W];
      out_ch.last_box  <= s1_last;
    end
  end

  assign out_ch.valid = o_valid;

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    (is_cell && (n_boxes != '0)) |-> (CNT_W'(cnt) < n_boxes))
    else $error("box counter past prior count");

  a_out_prior_range: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (CNT_W'(out_ch.box_prior) < n_boxes))
    else $error("box index beyond prior count");

  a_table_write: assert property (@(posedge clk) disable iff (rst)
    (head_valid && (head.kind == ITEM_LOAD)) |=>
      tbl_w[$past(head.prior_index)] == $past(head.half_width))
    else $error("prior table not written by load");

endmodule

FILE: hw/rtl/anchor_box_generator.sv
// A cell's first box is registered in the queue, the stage 1 registers and the output register in turn.
// One box per cycle while the output is not stalled; a cell gives prior_count boxes (16 at most,
// none if the count is zero), a load none; the sequencer issues one prior per cycle while it advances.
// A two-entry queue lets input transfers continue while boxes wait at the output.
// Reset: configuration registers take their defaults, queue and pipeline empty; prior table
// contents are undefined until loaded.
module anchor_box_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  abg_pkg::cfg_index_t           cfg_index,
  input  logic [abg_pkg::CFG_DATA_W-1:0] cfg_write_data,
  abg_in_if.sink                        in_ch,
  abg_out_if.source                     out_ch
);
  import abg_pkg::*;

  cfg_t         cfg;
  logic         q_ready;
  logic         push;
  queue_entry_t wr_entry;
  logic         head_valid;
  queue_entry_t head;
  logic         pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_x           <= STEP_W'(128);
      cfg.step_y           <= STEP_W'(128);
      cfg.center_offset    <= OFFSET_W'(128);
      cfg.inv_image_width  <= INV_W'(65536);
      cfg.inv_image_height <= INV_W'(65536);
      cfg.clip_enable      <= 1'b0;
      cfg.prior_count      <= PCOUNT_W'(1);
      cfg.variances_packed <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_STEP_X:      cfg.step_x           <= cfg_write_data[STEP_W-1:0];
        CFG_STEP_Y:      cfg.step_y           <= cfg_write_data[STEP_W-1:0];
        CFG_CENTER_OFS:  cfg.center_offset    <= cfg_write_data[OFFSET_W-1:0];
        CFG_INV_WIDTH:   cfg.inv_image_width  <= cfg_write_data[INV_W-1:0];
        CFG_INV_HEIGHT:  cfg.inv_image_height <= cfg_write_data[INV_W-1:0];
        CFG_CLIP_EN:     cfg.clip_enable      <= cfg_write_data[0];
        CFG_PRIOR_COUNT: cfg.prior_count      <= cfg_write_data[PCOUNT_W-1:0];
        CFG_VARIANCES:   cfg.variances_packed <= cfg_write_data[VARS_W-1:0];
        default:         cfg.step_x           <= cfg.step_x;
      endcase
    end
  end

  abg_front u_front (
    .cfg     (cfg),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .push    (push),
    .entry   (wr_entry)
  );

  abg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (wr_entry),
    .ready      (q_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  abg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
